@@ rtl/wrsp_pkg.sv @@
// Package for the WAV RIFF stream parser: result type, byte class and status codes.
// Used by wrsp_core.sv and wav_riff_stream_parser_top.sv; depends on nothing else.
package wrsp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned ClassW  = 3;
  localparam int unsigned StatusW = 4;
  localparam int unsigned OutW    = 176;

  // Byte class codes.
  localparam logic [ClassW-1:0] CLS_RIFF_HDR  = 3'd0;
  localparam logic [ClassW-1:0] CLS_CHUNK_HDR = 3'd1;
  localparam logic [ClassW-1:0] CLS_FMT_FIELD = 3'd2;
  localparam logic [ClassW-1:0] CLS_FMT_EXT   = 3'd3;
  localparam logic [ClassW-1:0] CLS_DATA      = 3'd4;
  localparam logic [ClassW-1:0] CLS_OTHER     = 3'd5;
  localparam logic [ClassW-1:0] CLS_PAD       = 3'd6;
  localparam logic [ClassW-1:0] CLS_IGNORED   = 3'd7;

  // Status codes, nonzero only on the last byte of a file.
  localparam logic [StatusW-1:0] ST_PARSING   = 4'd0;
  localparam logic [StatusW-1:0] ST_OK        = 4'd1;
  localparam logic [StatusW-1:0] ST_NOT_RIFF  = 4'd2;
  localparam logic [StatusW-1:0] ST_NOT_WAVE  = 4'd3;
  localparam logic [StatusW-1:0] ST_SIZE_MISM = 4'd4;
  localparam logic [StatusW-1:0] ST_FMT_SMALL = 4'd5;
  localparam logic [StatusW-1:0] ST_TRUNCATED = 4'd6;
  localparam logic [StatusW-1:0] ST_NO_FMT    = 4'd7;
  localparam logic [StatusW-1:0] ST_NO_DATA   = 4'd8;

  typedef struct packed {
    logic [ClassW-1:0]  byte_class;
    logic [ByteW-1:0]   byte_echo;
    logic [StatusW-1:0] status;
    logic [15:0]        audio_format;
    logic [15:0]        channel_count;
    logic [31:0]        sample_rate;
    logic [31:0]        byte_rate;
    logic [15:0]        block_align;
    logic [15:0]        bits_per_sample;
    logic [31:0]        data_length;
  } result_t;

endpackage

@@ rtl/wrsp_core.sv @@
// Parser state and per-byte next-state logic of the WAV RIFF stream parser.
// Depends on wrsp_pkg for the result type and the class and status codes.
module wrsp_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [wrsp_pkg::ByteW-1:0] byte_i,
  input  logic                      last_i,
  output wrsp_pkg::result_t         result_o
);

  localparam logic [3:0] PH_RIFF_ID   = 4'd0;
  localparam logic [3:0] PH_RIFF_SIZE = 4'd1;
  localparam logic [3:0] PH_WAVE      = 4'd2;
  localparam logic [3:0] PH_CK_ID     = 4'd3;
  localparam logic [3:0] PH_CK_SIZE   = 4'd4;
  localparam logic [3:0] PH_FMT_FIELD = 4'd5;
  localparam logic [3:0] PH_FMT_EXT   = 4'd6;
  localparam logic [3:0] PH_DATA      = 4'd7;
  localparam logic [3:0] PH_OTHER     = 4'd8;
  localparam logic [3:0] PH_PAD       = 4'd9;
  localparam logic [3:0] PH_IGNORED   = 4'd10;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_FMT   = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;

  localparam logic [31:0] ID_RIFF = 32'h4646_4952;
  localparam logic [31:0] ID_WAVE = 32'h4556_4157;
  localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;
  localparam logic [31:0] FMT_BODY_LEN = 32'd16;
  localparam logic [32:0] POS_MAX = 33'h1_FFFF_FFFF;

  logic [3:0]  phase_q, phase_d;
  logic [32:0] pos_q, pos_d;
  logic [32:0] riff_end_q, riff_end_d;
  logic [31:0] remaining_q, remaining_d;
  logic [31:0] shift_q, shift_d;
  logic [4:0]  group_q, group_d;
  logic [1:0]  kind_q, kind_d;
  logic        odd_pad_q, odd_pad_d;
  logic        saw_fmt_q, saw_fmt_d;
  logic        saw_data_q, saw_data_d;
  logic [3:0]  err_q, err_d;
  logic [15:0] audio_q, audio_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic [31:0] brate_q, brate_d;
  logic [15:0] align_q, align_d;
  logic [15:0] bits_q, bits_d;
  logic [31:0] dlen_q, dlen_d;

  logic [wrsp_pkg::ClassW-1:0]  cls;
  logic [wrsp_pkg::StatusW-1:0] status;

  always_comb begin
    logic        gather;
    logic [3:0]  cur_phase;
    logic [31:0] size;
    phase_d     = phase_q;
    riff_end_d  = riff_end_q;
    remaining_d = remaining_q;
    kind_d      = kind_q;
    odd_pad_d   = odd_pad_q;
    saw_fmt_d   = saw_fmt_q;
    saw_data_d  = saw_data_q;
    err_d       = err_q;
    audio_d     = audio_q;
    chan_d      = chan_q;
    rate_d      = rate_q;
    brate_d     = brate_q;
    align_d     = align_q;
    bits_d      = bits_q;
    dlen_d      = dlen_q;
    cls         = wrsp_pkg::CLS_IGNORED;
    status      = wrsp_pkg::ST_PARSING;

    gather    = (phase_q <= PH_CK_SIZE) || (phase_q == PH_FMT_FIELD);
    cur_phase = phase_q;
    // A chunk header that would start at or past the RIFF end closes the walk.
    if (phase_q == PH_CK_ID && group_q == 5'd0 && pos_q >= riff_end_q) begin
      cur_phase = PH_IGNORED;
      phase_d   = PH_IGNORED;
      gather    = 1'b0;
    end
    shift_d = gather ? {byte_i, shift_q[31:8]} : shift_q;
    group_d = gather ? group_q + 5'd1 : group_q;
    size    = shift_d;

    unique case (cur_phase)
      PH_RIFF_ID: begin
        cls = wrsp_pkg::CLS_RIFF_HDR;
        if (group_d == 5'd4) begin
          if (shift_d != ID_RIFF) err_d = wrsp_pkg::ST_NOT_RIFF;
          group_d = 5'd0;
          phase_d = PH_RIFF_SIZE;
        end
      end
      PH_RIFF_SIZE: begin
        cls = wrsp_pkg::CLS_RIFF_HDR;
        if (group_d == 5'd4) begin
          riff_end_d = {1'b0, shift_d} + 33'd8;
          group_d    = 5'd0;
          phase_d    = (err_q != 4'd0) ? PH_IGNORED : PH_WAVE;
        end
      end
      PH_WAVE: begin
        cls = wrsp_pkg::CLS_RIFF_HDR;
        if (group_d == 5'd4) begin
          group_d = 5'd0;
          if (shift_d != ID_WAVE) begin
            err_d   = wrsp_pkg::ST_NOT_WAVE;
            phase_d = PH_IGNORED;
          end else begin
            phase_d = PH_CK_ID;
          end
        end
      end
      PH_CK_ID: begin
        cls = wrsp_pkg::CLS_CHUNK_HDR;
        if (group_d == 5'd4) begin
          if (shift_d == ID_FMT) kind_d = KIND_FMT;
          else if (shift_d == ID_DATA) kind_d = KIND_DATA;
          else kind_d = KIND_OTHER;
          group_d = 5'd0;
          phase_d = PH_CK_SIZE;
        end
      end
      PH_CK_SIZE: begin
        cls = wrsp_pkg::CLS_CHUNK_HDR;
        if (group_d == 5'd4) begin
          group_d   = 5'd0;
          odd_pad_d = size[0];
          if (kind_q == KIND_FMT) begin
            if (size < FMT_BODY_LEN) begin
              err_d   = wrsp_pkg::ST_FMT_SMALL;
              phase_d = PH_IGNORED;
            end else begin
              remaining_d = size - FMT_BODY_LEN;
              phase_d     = PH_FMT_FIELD;
            end
          end else begin
            if (kind_q == KIND_DATA) dlen_d = size;
            remaining_d = size;
            if (size == 32'd0) begin
              if (kind_q == KIND_DATA) saw_data_d = 1'b1;
              // An even size leaves no pad byte, so the walk goes straight on.
              odd_pad_d = 1'b0;
              phase_d   = PH_CK_ID;
            end else begin
              phase_d = (kind_q == KIND_DATA) ? PH_DATA : PH_OTHER;
            end
          end
        end
      end
      PH_FMT_FIELD: begin
        cls = wrsp_pkg::CLS_FMT_FIELD;
        unique case (group_d)
          5'd2:    audio_d = shift_d[31:16];
          5'd4:    chan_d  = shift_d[31:16];
          5'd8:    rate_d  = shift_d;
          5'd12:   brate_d = shift_d;
          5'd14:   align_d = shift_d[31:16];
          5'd16:   bits_d  = shift_d[31:16];
          default: ;
        endcase
        if (group_d >= 5'd16) begin
          group_d   = 5'd0;
          saw_fmt_d = 1'b1;
          if (remaining_q == 32'd0) begin
            phase_d   = odd_pad_q ? PH_PAD : PH_CK_ID;
            odd_pad_d = 1'b0;
          end else begin
            phase_d = PH_FMT_EXT;
          end
        end
      end
      PH_FMT_EXT, PH_DATA, PH_OTHER: begin
        if (cur_phase == PH_FMT_EXT) cls = wrsp_pkg::CLS_FMT_EXT;
        else if (cur_phase == PH_DATA) cls = wrsp_pkg::CLS_DATA;
        else cls = wrsp_pkg::CLS_OTHER;
        if (remaining_q != 32'd0) remaining_d = remaining_q - 32'd1;
        if (remaining_d == 32'd0) begin
          if (cur_phase == PH_DATA) saw_data_d = 1'b1;
          phase_d   = odd_pad_q ? PH_PAD : PH_CK_ID;
          odd_pad_d = 1'b0;
        end
      end
      PH_PAD: begin
        cls     = wrsp_pkg::CLS_PAD;
        phase_d = PH_CK_ID;
      end
      default: begin
        cls = wrsp_pkg::CLS_IGNORED;
      end
    endcase

    pos_d = (pos_q != POS_MAX) ? pos_q + 33'd1 : pos_q;

    if (last_i) begin
      // Final verdict, in order of precedence.
      if (phase_d == PH_RIFF_ID || phase_d == PH_RIFF_SIZE) status = wrsp_pkg::ST_TRUNCATED;
      else if (phase_d == PH_WAVE) status = wrsp_pkg::ST_NOT_WAVE;
      else if (err_d == wrsp_pkg::ST_NOT_RIFF || err_d == wrsp_pkg::ST_NOT_WAVE) status = err_d;
      else if (pos_d != riff_end_d) status = wrsp_pkg::ST_SIZE_MISM;
      else if (err_d != 4'd0) status = err_d;
      else if (!((phase_d == PH_CK_ID && group_d == 5'd0) || phase_d == PH_PAD ||
                 phase_d == PH_IGNORED)) status = wrsp_pkg::ST_TRUNCATED;
      else if (!saw_fmt_d) status = wrsp_pkg::ST_NO_FMT;
      else if (!saw_data_d) status = wrsp_pkg::ST_NO_DATA;
      else status = wrsp_pkg::ST_OK;
    end
  end

  always_comb begin
    result_o.byte_class      = cls;
    result_o.byte_echo       = byte_i;
    result_o.status          = status;
    result_o.audio_format    = audio_d;
    result_o.channel_count   = chan_d;
    result_o.sample_rate     = rate_d;
    result_o.byte_rate       = brate_d;
    result_o.block_align     = align_d;
    result_o.bits_per_sample = bits_d;
    result_o.data_length     = dlen_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_RIFF_ID;
      pos_q       <= '0;
      riff_end_q  <= '0;
      remaining_q <= '0;
      shift_q     <= '0;
      group_q     <= '0;
      kind_q      <= KIND_OTHER;
      odd_pad_q   <= 1'b0;
      saw_fmt_q   <= 1'b0;
      saw_data_q  <= 1'b0;
      err_q       <= '0;
      audio_q     <= '0;
      chan_q      <= '0;
      rate_q      <= '0;
      brate_q     <= '0;
      align_q     <= '0;
      bits_q      <= '0;
      dlen_q      <= '0;
    end else if (accept_i && last_i) begin
      // The last byte closes the file and everything returns to its reset value.
      phase_q     <= PH_RIFF_ID;
      pos_q       <= '0;
      riff_end_q  <= '0;
      remaining_q <= '0;
      shift_q     <= '0;
      group_q     <= '0;
      kind_q      <= KIND_OTHER;
      odd_pad_q   <= 1'b0;
      saw_fmt_q   <= 1'b0;
      saw_data_q  <= 1'b0;
      err_q       <= '0;
      audio_q     <= '0;
      chan_q      <= '0;
      rate_q      <= '0;
      brate_q     <= '0;
      align_q     <= '0;
      bits_q      <= '0;
      dlen_q      <= '0;
    end else if (accept_i) begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      riff_end_q  <= riff_end_d;
      remaining_q <= remaining_d;
      shift_q     <= shift_d;
      group_q     <= group_d;
      kind_q      <= kind_d;
      odd_pad_q   <= odd_pad_d;
      saw_fmt_q   <= saw_fmt_d;
      saw_data_q  <= saw_data_d;
      err_q       <= err_d;
      audio_q     <= audio_d;
      chan_q      <= chan_d;
      rate_q      <= rate_d;
      brate_q     <= brate_d;
      align_q     <= align_d;
      bits_q      <= bits_d;
      dlen_q      <= dlen_d;
    end
  end

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_i |=> phase_q == PH_RIFF_ID && pos_q == 33'd0)
    else $error("parser did not restart after the last byte");

  a_group_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_FMT_FIELD |-> group_q <= 5'd4)
    else $error("byte group count ran past a four-byte group");

  a_pad_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAD |-> !odd_pad_q)
    else $error("pad flag still set while skipping the pad byte");

endmodule

@@ rtl/wav_riff_stream_parser_top.sv @@
// Top level of the WAV RIFF stream parser: stream handshake and result register.
// Depends on wrsp_pkg and instantiates wrsp_core.
//
// Channel   Dir  Handshake                       Payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o  tdata: byte_value; tlast: last_byte
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i  tuser: byte_class; tdata: echo, status,
//                                                 fmt fields and data length
//
// Every accepted byte yields exactly one result request in the following cycle; a byte
// can be taken in every cycle, since the parser state and the result register both
// update as it is accepted. The single result register decides the rate: a new byte is
// taken whenever that register is empty or its content is taken in the same cycle.
// Reset (rst_ni low, asynchronous) returns the parser to the RIFF id and empties the
// result register. A stall on m_axis holds the result and back-pressures s_axis.
module wav_riff_stream_parser_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // tdata fields from bit 0: byte_value[7:0].
  input  logic [wrsp_pkg::ByteW-1:0]  s_axis_tdata_i,
  input  logic                        s_axis_tlast_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // tuser fields from bit 0: byte_class[2:0].
  output logic [wrsp_pkg::ClassW-1:0] m_axis_tuser_o,
  // tdata fields from bit 0: byte_echo[7:0], status[11:8], audio_format[27:12],
  // channel_count[43:28], sample_rate[75:44], byte_rate[107:76], block_align[123:108],
  // bits_per_sample[139:124], data_length[171:140], zero[175:172].
  output logic [wrsp_pkg::OutW-1:0]   m_axis_tdata_o
);

  logic              in_accept;
  logic              out_valid_q, out_valid_d;
  wrsp_pkg::result_t core_result;
  wrsp_pkg::result_t result_q;

  // The register can take a new request when empty or when it drains this cycle.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign out_valid_d     = in_accept || (out_valid_q && !m_axis_tready_i);

  wrsp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .byte_i   (s_axis_tdata_i),
    .last_i   (s_axis_tlast_i),
    .result_o (core_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Payload register: needs no reset, qualified by out_valid_q.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      result_q <= core_result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = result_q.byte_class;
  assign m_axis_tdata_o  = {4'b0,
                            result_q.data_length,
                            result_q.bits_per_sample,
                            result_q.block_align,
                            result_q.byte_rate,
                            result_q.sample_rate,
                            result_q.channel_count,
                            result_q.audio_format,
                            result_q.status,
                            result_q.byte_echo};

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> m_axis_tvalid_o && m_axis_tdata_o[7:0] == $past(s_axis_tdata_i))
    else $error("accepted byte did not reach the result register");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input taken while a stalled result is pending");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !s_axis_tvalid_i |=> !m_axis_tvalid_o)
    else $error("result register stayed full after draining");

endmodule
